### sv/arsp_pkg.sv
// ----------------------------------------------------------------------------
// Adaptive request-size policy package
// Shared constants, action codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package arsp_pkg;

  localparam int SIZE_BITS_DEF = 16;
  localparam int BYTE_BITS_DEF = 32;
  localparam int CAP_BITS      = 32;
  localparam int COUNT_BITS    = 32;

  localparam logic [31:0] START_RESET    = 32'd300;
  localparam logic [31:0] LEAST_RESET    = 32'd1;
  localparam logic [31:0] GREATEST_RESET = 32'd1000;

  typedef enum logic [1:0] {
    ACT_RESTART = 2'd0,
    ACT_ASK     = 2'd1,
    ACT_OBSERVE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    REG_START    = 2'd0,
    REG_LEAST    = 2'd1,
    REG_GREATEST = 2'd2,
    REG_BUDGET   = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PER,
    ST_TGT,
    ST_OUT
  } state_t;

endpackage

### sv/arsp_divider.sv
// ----------------------------------------------------------------------------
// Adaptive request-size policy divider
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module arsp_divider #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_BITS = $clog2(W + 1);

  logic [W:0]          rem;
  logic [W-1:0]        quo;
  logic [W-1:0]        dsr;
  logic [CNT_BITS-1:0] cnt;
  logic [W:0]          rem_shift;
  logic                fits;

  assign rem_shift = {rem[W-1:0], quo[W-1]};
  assign fits      = rem_shift >= {1'b0, dsr};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? (rem_shift - {1'b0, dsr}) : rem_shift;
      quo <= {quo[W-2:0], fits};
    end
  end

endmodule

### sv/adaptive_request_size_policy.sv
// ----------------------------------------------------------------------------
// Adaptive request-size policy
// Request-size limit with restart, ask and observe; a qualifying observe shrinks the limit.
// ----------------------------------------------------------------------------
// Restart, ask, unused codes and declined observes: result valid the cycle after
// the item is taken. A shrinking observe runs two divisions on one restoring
// divider of max(SIZE_BITS,BYTE_BITS)+1 bits, one bit a cycle. One item at a
// time; a new item is taken the cycle after the result is taken. Reset loads
// default registers, the clamped start limit and a zero shrink count.
module adaptive_request_size_policy #(
  parameter int SIZE_BITS = arsp_pkg::SIZE_BITS_DEF,
  parameter int BYTE_BITS = arsp_pkg::BYTE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [1:0]                              cfg_index,
  input  logic [((SIZE_BITS > BYTE_BITS) ? SIZE_BITS : BYTE_BITS)-1:0] cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              action,
  input  logic [arsp_pkg::CAP_BITS-1:0]           request_cap,
  input  logic [SIZE_BITS-1:0]                    docs_in_response,
  input  logic [BYTE_BITS-1:0]                    bytes_in_response,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [SIZE_BITS-1:0]                    granted_size,
  output logic                                    did_shrink,
  output logic [SIZE_BITS-1:0]                    limit_now,
  output logic [arsp_pkg::COUNT_BITS-1:0]         shrink_total
);

  localparam int MAXW = (SIZE_BITS > BYTE_BITS) ? SIZE_BITS : BYTE_BITS;
  localparam int W    = MAXW + 1;
  localparam int CW   = arsp_pkg::CAP_BITS;

  localparam logic [SIZE_BITS-1:0] RST_START    = SIZE_BITS'(arsp_pkg::START_RESET);
  localparam logic [SIZE_BITS-1:0] RST_LEAST    = SIZE_BITS'(arsp_pkg::LEAST_RESET);
  localparam logic [SIZE_BITS-1:0] RST_GREATEST = SIZE_BITS'(arsp_pkg::GREATEST_RESET);
  localparam logic [SIZE_BITS-1:0] RST_LIMIT    = (RST_START < RST_LEAST) ? RST_LEAST :
                                                  (RST_START > RST_GREATEST) ? RST_GREATEST :
                                                  RST_START;

  arsp_pkg::state_t state, state_next;

  logic [SIZE_BITS-1:0]            start_lim;
  logic [SIZE_BITS-1:0]            least_lim;
  logic [SIZE_BITS-1:0]            greatest_lim;
  logic [BYTE_BITS-1:0]            budget;
  logic [SIZE_BITS-1:0]            limit;
  logic [arsp_pkg::COUNT_BITS-1:0] shrinks;

  logic                  div_start;
  logic [W-1:0]          div_dividend;
  logic [W-1:0]          div_divisor;
  logic                  div_busy;
  logic                  div_done;
  logic [W-1:0]          div_quot;

  logic                  in_take;
  logic                  obs_go;
  logic [SIZE_BITS-1:0]  restart_limit;
  logic [CW-1:0]         limit_cap;
  logic [SIZE_BITS-1:0]  ask_grant;
  logic [W-1:0]          ceiling;
  logic [W-1:0]          tgt_ceil;
  logic [SIZE_BITS-1:0]  shrunk_limit;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == arsp_pkg::ST_IDLE);
  assign in_take   = in_valid && in_ready;

  assign obs_go = (action == arsp_pkg::ACT_OBSERVE) && (budget != '0) &&
                  (bytes_in_response > budget) && (docs_in_response != '0) &&
                  (limit > least_lim);

  assign restart_limit = (start_lim < least_lim) ? least_lim :
                         (start_lim > greatest_lim) ? greatest_lim : start_lim;

  assign limit_cap = CW'(limit);
  assign ask_grant = ((request_cap != '0) && (request_cap < limit_cap)) ?
                     SIZE_BITS'(request_cap) : limit;

  assign ceiling      = W'(limit) - W'(1);
  assign tgt_ceil     = (div_quot > ceiling) ? ceiling : div_quot;
  assign shrunk_limit = (tgt_ceil < W'(least_lim)) ? least_lim : SIZE_BITS'(tgt_ceil);

  arsp_divider #(
    .W(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = W'(budget);
    div_divisor  = div_quot;
    case (state)
      arsp_pkg::ST_IDLE: begin
        div_dividend = W'(bytes_in_response) + W'(docs_in_response) - W'(1);
        div_divisor  = W'(docs_in_response);
        if (in_take) begin
          if (obs_go) begin
            div_start  = 1'b1;
            state_next = arsp_pkg::ST_PER;
          end else begin
            state_next = arsp_pkg::ST_OUT;
          end
        end
      end
      arsp_pkg::ST_PER: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = arsp_pkg::ST_TGT;
        end
      end
      arsp_pkg::ST_TGT: begin
        if (div_done) begin
          state_next = arsp_pkg::ST_OUT;
        end
      end
      arsp_pkg::ST_OUT: begin
        if (out_ready) begin
          state_next = arsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = arsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign out_valid = (state == arsp_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_lim    <= RST_START;
      least_lim    <= RST_LEAST;
      greatest_lim <= RST_GREATEST;
      budget       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        arsp_pkg::REG_START:    start_lim    <= cfg_data[SIZE_BITS-1:0];
        arsp_pkg::REG_LEAST:    least_lim    <= cfg_data[SIZE_BITS-1:0];
        arsp_pkg::REG_GREATEST: greatest_lim <= cfg_data[SIZE_BITS-1:0];
        arsp_pkg::REG_BUDGET:   budget       <= cfg_data[BYTE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit   <= RST_LIMIT;
      shrinks <= '0;
    end else if (in_take && action == arsp_pkg::ACT_RESTART) begin
      limit   <= restart_limit;
      shrinks <= '0;
    end else if (state == arsp_pkg::ST_TGT && div_done) begin
      limit <= shrunk_limit;
      if (shrinks != '1) begin
        shrinks <= shrinks + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      did_shrink   <= 1'b0;
      limit_now    <= limit;
      shrink_total <= shrinks;
      case (action)
        arsp_pkg::ACT_RESTART: begin
          granted_size <= restart_limit;
          limit_now    <= restart_limit;
          shrink_total <= '0;
        end
        arsp_pkg::ACT_ASK: granted_size <= ask_grant;
        default:           granted_size <= limit;
      endcase
    end else if (state == arsp_pkg::ST_TGT && div_done) begin
      did_shrink   <= 1'b1;
      granted_size <= shrunk_limit;
      limit_now    <= shrunk_limit;
      shrink_total <= (shrinks != '1) ? shrinks + 1'b1 : shrinks;
    end
  end

`ifndef SYNTHESIS
  a_div_in_seq: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == arsp_pkg::ST_PER || state == arsp_pkg::ST_TGT))
    else $error("divider busy outside a division state");

  a_tgt_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == arsp_pkg::ST_TGT && div_done) |=> out_valid && did_shrink)
    else $error("shrink result not presented");

  a_shrink_floor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && did_shrink) |-> (limit_now >= least_lim && limit_now == limit))
    else $error("shrunk limit below least or not stored");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |-> !out_valid && !div_busy)
    else $error("item taken while busy");
`endif

endmodule
